@@ design/avr_pkg.sv @@
// Shared constants for the axis-angle vector rotator.
// Holds the CORDIC arctangent table, the gain and the fixed widths of the
// axis normalization path. No dependencies.
package avr_pkg;

	// arctangent of 2^-i in turn units, 2^32 per full turn
	localparam int ATAN_N = 24;
	localparam logic [31:0] ATAN_TURN [0:ATAN_N-1] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// inverse CORDIC gain (1/K, about 0.6073), Q0.32
	localparam logic [31:0] CORDIC_GAIN_Q32 = 32'h9B74EDA8;

	// phase accumulator width inside the rotator
	localparam int PHASE_W = 32;

	// axis magnitudes are block-shifted so the largest has its msb at bit 29
	localparam int NORM_W = 30;
	// sum of three squares of NORM_W-bit values
	localparam int SQ_W = 62;
	// one root bit per cell
	localparam int SQRT_STEPS = 31;
	// axis length width
	localparam int LEN_W = 31;

endpackage

@@ design/avr_sqrt_cell.sv @@
// One cell of the integer square root chain: settles one root bit.
// Uses avr_pkg for the word widths.
module avr_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [avr_pkg::SQ_W-1:0]  rem_in,
	input  logic [avr_pkg::SQ_W-1:0]  root_in,
	output logic [avr_pkg::SQ_W-1:0]  rem_out,
	output logic [avr_pkg::SQ_W-1:0]  root_out
);

	localparam logic [avr_pkg::SQ_W-1:0] BIT_VAL =
		avr_pkg::SQ_W'(1) << (2 * (avr_pkg::SQRT_STEPS - 1 - STEP));

	logic [avr_pkg::SQ_W-1:0] trial;
	logic                     ge;

	assign trial = root_in + BIT_VAL;
	assign ge    = rem_in >= trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= ge ? rem_in - trial : rem_in;
			root_out <= ge ? (root_in >> 1) + BIT_VAL : root_in >> 1;
		end
	end

endmodule

@@ design/avr_cordic_cell.sv @@
// One CORDIC rotation cell: a fixed shift and one arctangent constant.
// Uses avr_pkg for the arctangent table.
module avr_cordic_cell #(
	parameter int XY_W = 31,
	parameter int STEP = 0
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [XY_W-1:0]              x_in,
	input  logic signed [XY_W-1:0]              y_in,
	input  logic signed [avr_pkg::PHASE_W-1:0]  z_in,
	output logic signed [XY_W-1:0]              x_out,
	output logic signed [XY_W-1:0]              y_out,
	output logic signed [avr_pkg::PHASE_W-1:0]  z_out
);

	localparam logic signed [avr_pkg::PHASE_W-1:0] ATAN =
		signed'(avr_pkg::ATAN_TURN[STEP]);

	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;
	logic                   fwd;

	assign dx  = y_in >>> STEP;
	assign dy  = x_in >>> STEP;
	assign fwd = !z_in[avr_pkg::PHASE_W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			x_out <= fwd ? x_in - dx : x_in + dx;
			y_out <= fwd ? y_in + dy : y_in - dy;
			z_out <= fwd ? z_in - ATAN : z_in + ATAN;
		end
	end

endmodule

@@ design/avr_div_cell.sv @@
// One restoring division cell: shifts in one numerator bit, settles one
// quotient bit. Uses avr_pkg for the divisor width.
module avr_div_cell #(
	parameter int LOW_W = 29
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [avr_pkg::LEN_W-1:0]   dvs,
	input  logic [avr_pkg::LEN_W-1:0]   rem_in,
	input  logic [LOW_W-1:0]            low_in,
	input  logic [LOW_W-1:0]            quo_in,
	output logic [avr_pkg::LEN_W-1:0]   rem_out,
	output logic [LOW_W-1:0]            low_out,
	output logic [LOW_W-1:0]            quo_out
);

	logic [avr_pkg::LEN_W:0] trial;
	logic [avr_pkg::LEN_W:0] diff;
	logic                    ge;

	assign trial = {rem_in, low_in[LOW_W-1]};
	assign diff  = trial - {1'b0, dvs};
	assign ge    = trial >= {1'b0, dvs};

	// remainder stays below the divisor, so it fits LEN_W bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= ge ? diff[avr_pkg::LEN_W-1:0] : trial[avr_pkg::LEN_W-1:0];
			low_out <= low_in << 1;
			quo_out <= {quo_in[LOW_W-2:0], ge};
		end
	end

endmodule

@@ design/axis_angle_vector_rotate.sv @@
// Axis-angle vector rotation (Rodrigues), fully pipelined.
// Depends on avr_pkg and the cells avr_sqrt_cell, avr_cordic_cell, avr_div_cell.
//
// Usage:
//   Slave stream carries one request per beat: vector, axis (any length) and
//   a turn angle, packed into s_axis_tdata. Master stream returns the rotated
//   vector in m_axis_tdata, with axis_zero and saturated in m_axis_tuser.
//   A zero axis passes the vector through and raises axis_zero.
// Throughput: one request per cycle while the output is free or being taken.
// Depth: set by the 31-cell square root chain and the U+1-cell divider chain
//   that normalize the axis, U = min(60 - COMP_WIDTH, 30); the CORDIC cells
//   run beside the root chain.
// Stall: the whole pipeline advances on one enable; when the output register
//   holds a result the receiver does not take, every stage holds and
//   s_axis_tready drops. While the output is free or being taken, a new
//   request enters each cycle.
// Reset: arst_n clears all valid flags; no result is pending after reset.
module axis_angle_vector_rotate #(
	parameter int COMP_WIDTH    = 32,
	parameter int ANGLE_BITS    = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle, zero fill
	input  logic [((6*COMP_WIDTH+ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_x, out_y, out_z, zero fill
	output logic [((3*COMP_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// axis_zero, saturated
	output logic [1:0] m_axis_tuser
);

	localparam int CW     = COMP_WIDTH;
	localparam int U      = ((60 - CW) < 30) ? (60 - CW) : 30;
	localparam int NST    = (CORDIC_STAGES < avr_pkg::ATAN_N) ? CORDIC_STAGES
	                                                          : avr_pkg::ATAN_N;
	localparam int NORM_W = avr_pkg::NORM_W;
	localparam int SQ_W   = avr_pkg::SQ_W;
	localparam int SQ_N   = avr_pkg::SQRT_STEPS;
	localparam int LEN_W  = avr_pkg::LEN_W;
	localparam int PH_W   = avr_pkg::PHASE_W;
	localparam int XY_W   = U + 3;
	localparam int K_W    = U + 2;
	localparam int Q_W    = U + 1;
	localparam int OMC_W  = U + 3;
	localparam int NUM_W  = U + 31;
	localparam int C_W    = CW + 2;
	localparam int D_W    = CW + 3;
	localparam int P1_W   = CW + K_W;
	localparam int P2_W   = C_W + K_W;
	localparam int T1_W   = D_W + OMC_W;
	localparam int T2_W   = C_W + K_W;
	localparam int ACC_W  = T1_W + 2;
	localparam int MSB_W  = $clog2(CW);
	localparam int OUT_TW = ((3*CW+7)/8)*8;
	localparam int PIPE_D = 4 + SQ_N + 1 + Q_W + 6;

	localparam logic [63:0] XINIT64 =
		(64'(avr_pkg::CORDIC_GAIN_Q32) + (64'd1 << (31 - U))) >> (32 - U);
	localparam logic signed [XY_W-1:0] XINIT = XY_W'(XINIT64);
	localparam logic signed [XY_W-1:0] ONE_XY = XY_W'(1) <<< U;
	localparam logic signed [ACC_W-1:0] SAT_HI =
		{{(ACC_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

	typedef struct packed {
		logic                       zero;
		logic [2:0]                 neg;
		logic [1:0]                 quad;
		logic [2:0][CW-1:0]         vec;
		logic [2:0][NORM_W-1:0]     mag;
	} side_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [OMC_W-1:0]  omc;
		logic [K_W-1:0]    sn;
	} trig_t;

	logic en;
	logic [PIPE_D-1:0] vld_q;
	logic out_vld_q;

	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_q     <= {vld_q[PIPE_D-2:0], s_axis_tvalid};
			out_vld_q <= vld_q[PIPE_D-1];
		end
	end

	// s1: unpack, axis sign and magnitude
	logic [2:0][CW-1:0] vec_s1;
	logic [2:0][CW-1:0] mag_s1;
	logic [2:0]         neg_s1;
	logic [ANGLE_BITS-1:0] ang_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				vec_s1[i] <= s_axis_tdata[i*CW +: CW];
				neg_s1[i] <= s_axis_tdata[(3+i)*CW + CW - 1];
				mag_s1[i] <= s_axis_tdata[(3+i)*CW + CW - 1]
				             ? CW'(-s_axis_tdata[(3+i)*CW +: CW])
				             : s_axis_tdata[(3+i)*CW +: CW];
			end
			ang_s1 <= s_axis_tdata[6*CW +: ANGLE_BITS];
		end
	end

	// s2: block normalization of the axis, rotator setup
	side_t s2_side;
	logic signed [XY_W-1:0] cx [0:SQ_N];
	logic signed [XY_W-1:0] cy [0:SQ_N];
	logic signed [PH_W-1:0] cz [0:NST];
	logic signed [XY_W-1:0] cx_s2, cy_s2, cx_s3, cy_s3;
	logic signed [PH_W-1:0] cz_s2, cz_s3;

	always_ff @(posedge clk) begin
		logic [CW-1:0]        any;
		logic [MSB_W-1:0]     msb;
		logic [CW+NORM_W-1:0] ext;
		logic [PH_W-1:0]      theta;
		logic [PH_W-1:0]      t;
		if (en) begin
			any = mag_s1[0] | mag_s1[1] | mag_s1[2];
			msb = '0;
			for (int b = 0; b < CW; b++) begin
				if (any[b]) begin
					msb = MSB_W'(b);
				end
			end
			for (int i = 0; i < 3; i++) begin
				ext = {mag_s1[i], NORM_W'(0)} << (MSB_W'(CW - 1) - msb);
				s2_side.mag[i] <= ext[CW+NORM_W-1 -: NORM_W];
			end
			s2_side.zero <= any == '0;
			s2_side.neg  <= neg_s1;
			s2_side.vec  <= vec_s1;
			theta = {ang_s1, {(PH_W-ANGLE_BITS){1'b0}}};
			t     = theta + 32'h2000_0000;
			s2_side.quad <= t[PH_W-1 -: 2];
			cz_s2 <= signed'({2'b00, t[PH_W-3:0]}) - 32'sh2000_0000;
			cx_s2 <= XINIT;
			cy_s2 <= '0;
		end
	end

	// s3: squares; s4: sum of squares
	side_t s3_side;
	logic [2:0][2*NORM_W-1:0] sq_s3;
	logic [SQ_W-1:0] sq_rem  [0:SQ_N];
	logic [SQ_W-1:0] sq_root [0:SQ_N];
	side_t           sq_side [0:SQ_N];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= s2_side.mag[i] * s2_side.mag[i];
			end
			s3_side <= s2_side;
			cx_s3   <= cx_s2;
			cy_s3   <= cy_s2;
			cz_s3   <= cz_s2;
			sq_rem[0]  <= SQ_W'(sq_s3[0]) + SQ_W'(sq_s3[1]) + SQ_W'(sq_s3[2]);
			sq_root[0] <= '0;
			sq_side[0] <= s3_side;
			cx[0] <= cx_s3;
			cy[0] <= cy_s3;
			cz[0] <= cz_s3;
		end
	end

	// square root chain, CORDIC cells alongside the first NST cells
	for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
		avr_sqrt_cell #(.STEP(j)) u_sqrt (
			.clk      (clk),
			.en       (en),
			.rem_in   (sq_rem[j]),
			.root_in  (sq_root[j]),
			.rem_out  (sq_rem[j+1]),
			.root_out (sq_root[j+1])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				sq_side[j+1] <= sq_side[j];
			end
		end

		if (j < NST) begin : g_rot
			avr_cordic_cell #(.XY_W(XY_W), .STEP(j)) u_rot (
				.clk   (clk),
				.en    (en),
				.x_in  (cx[j]),
				.y_in  (cy[j]),
				.z_in  (cz[j]),
				.x_out (cx[j+1]),
				.y_out (cy[j+1]),
				.z_out (cz[j+1])
			);
		end else begin : g_hold
			always_ff @(posedge clk) begin
				if (en) begin
					cx[j+1] <= cx[j];
					cy[j+1] <= cy[j];
				end
			end
		end
	end

	// division setup, sine/cosine clamp and quadrant map
	logic [LEN_W-1:0] dv_rem  [0:Q_W][0:2];
	logic [Q_W-1:0]   dv_low  [0:Q_W][0:2];
	logic [Q_W-1:0]   dv_quo  [0:Q_W][0:2];
	side_t            dv_side [0:Q_W];
	trig_t            dv_trig [0:Q_W];

	always_ff @(posedge clk) begin
		logic [LEN_W-1:0]        len;
		logic [NUM_W-1:0]        num;
		logic signed [XY_W-1:0]  xc;
		logic signed [XY_W-1:0]  yc;
		logic signed [K_W-1:0]   cs;
		logic signed [K_W-1:0]   sn;
		if (en) begin
			len = sq_root[SQ_N][LEN_W-1:0];
			for (int i = 0; i < 3; i++) begin
				num = NUM_W'({sq_side[SQ_N].mag[i], U'(0)}) + NUM_W'(len >> 1);
				dv_rem[0][i] <= LEN_W'(num[NUM_W-1:U+1]);
				dv_low[0][i] <= num[U:0];
				dv_quo[0][i] <= '0;
			end
			xc = (cx[SQ_N] > ONE_XY) ? ONE_XY : ((cx[SQ_N] < -ONE_XY) ? -ONE_XY : cx[SQ_N]);
			yc = (cy[SQ_N] > ONE_XY) ? ONE_XY : ((cy[SQ_N] < -ONE_XY) ? -ONE_XY : cy[SQ_N]);
			unique case (sq_side[SQ_N].quad)
				2'd0: begin
					cs = K_W'(xc);
					sn = K_W'(yc);
				end
				2'd1: begin
					cs = -K_W'(yc);
					sn = K_W'(xc);
				end
				2'd2: begin
					cs = -K_W'(xc);
					sn = -K_W'(yc);
				end
				default: begin
					cs = K_W'(yc);
					sn = -K_W'(xc);
				end
			endcase
			dv_trig[0].len <= len;
			dv_trig[0].omc <= (OMC_W'(1) << U) - OMC_W'(cs);
			dv_trig[0].sn  <= sn;
			dv_side[0]     <= sq_side[SQ_N];
		end
	end

	// divider chain: k = round(mag * 2^U / len), three lanes per step
	for (genvar j = 0; j < Q_W; j++) begin : g_div
		for (genvar l = 0; l < 3; l++) begin : g_lane
			avr_div_cell #(.LOW_W(Q_W)) u_div (
				.clk     (clk),
				.en      (en),
				.dvs     (dv_trig[j].len),
				.rem_in  (dv_rem[j][l]),
				.low_in  (dv_low[j][l]),
				.quo_in  (dv_quo[j][l]),
				.rem_out (dv_rem[j+1][l]),
				.low_out (dv_low[j+1][l]),
				.quo_out (dv_quo[j+1][l])
			);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_side[j+1] <= dv_side[j];
				dv_trig[j+1] <= dv_trig[j];
			end
		end
	end

	// s5: signed unit axis
	side_t s5_side, s6_side, s7_side, s8_side, s9_side;
	trig_t s5_trig, s6_trig, s7_trig, s8_trig, s9_trig;
	logic signed [K_W-1:0] k_s5 [0:2];
	logic signed [K_W-1:0] k_s6 [0:2];
	logic signed [K_W-1:0] k_s7 [0:2];
	logic signed [K_W-1:0] k_s8 [0:2];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				k_s5[i] <= dv_side[Q_W].neg[i] ? -signed'(K_W'(dv_quo[Q_W][i]))
				                               : signed'(K_W'(dv_quo[Q_W][i]));
			end
			s5_side <= dv_side[Q_W];
			s5_trig <= dv_trig[Q_W];
		end
	end

	// s6: products of v x k
	logic signed [P1_W-1:0] p_s6 [0:5];

	always_ff @(posedge clk) begin
		logic signed [P1_W-1:0] v [0:2];
		logic signed [P1_W-1:0] k [0:2];
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v[i] = P1_W'(signed'(s5_side.vec[i]));
				k[i] = P1_W'(k_s5[i]);
			end
			p_s6[0] <= v[1] * k[2];
			p_s6[1] <= v[2] * k[1];
			p_s6[2] <= v[2] * k[0];
			p_s6[3] <= v[0] * k[2];
			p_s6[4] <= v[0] * k[1];
			p_s6[5] <= v[1] * k[0];
			k_s6    <= k_s5;
			s6_side <= s5_side;
			s6_trig <= s5_trig;
		end
	end

	// s7: c = v x k, rounded back to vector scale
	logic signed [C_W-1:0] c_s7 [0:2];
	logic signed [C_W-1:0] c_s8 [0:2];
	logic signed [C_W-1:0] c_s9 [0:2];

	always_ff @(posedge clk) begin
		logic signed [P1_W:0] df;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				df = (P1_W+1)'(p_s6[2*i]) - (P1_W+1)'(p_s6[2*i+1])
				   + ((P1_W+1)'(1) <<< (U - 1));
				c_s7[i] <= C_W'(df >>> U);
			end
			k_s7    <= k_s6;
			s7_side <= s6_side;
			s7_trig <= s6_trig;
		end
	end

	// s8: products of c x k
	logic signed [P2_W-1:0] p_s8 [0:5];

	always_ff @(posedge clk) begin
		logic signed [P2_W-1:0] c [0:2];
		logic signed [P2_W-1:0] k [0:2];
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c[i] = P2_W'(c_s7[i]);
				k[i] = P2_W'(k_s7[i]);
			end
			p_s8[0] <= c[1] * k[2];
			p_s8[1] <= c[2] * k[1];
			p_s8[2] <= c[2] * k[0];
			p_s8[3] <= c[0] * k[2];
			p_s8[4] <= c[0] * k[1];
			p_s8[5] <= c[1] * k[0];
			c_s8    <= c_s7;
			k_s8    <= k_s7;
			s8_side <= s7_side;
			s8_trig <= s7_trig;
		end
	end

	// s9: d = c x k
	logic signed [D_W-1:0] d_s9 [0:2];

	always_ff @(posedge clk) begin
		logic signed [P2_W:0] df;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				df = (P2_W+1)'(p_s8[2*i]) - (P2_W+1)'(p_s8[2*i+1])
				   + ((P2_W+1)'(1) <<< (U - 1));
				d_s9[i] <= D_W'(df >>> U);
			end
			c_s9    <= c_s8;
			s9_side <= s8_side;
			s9_trig <= s8_trig;
		end
	end

	// s10: terms of v*2^U + d*(1-cos) - c*sin
	logic signed [ACC_W-1:0] t0_s10 [0:2];
	logic signed [T1_W-1:0]  t1_s10 [0:2];
	logic signed [T2_W-1:0]  t2_s10 [0:2];
	logic [2:0][CW-1:0]      vec_s10;
	logic                    zero_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				t0_s10[i] <= ACC_W'(signed'(s9_side.vec[i])) <<< U;
				t1_s10[i] <= T1_W'(d_s9[i]) * T1_W'(signed'(s9_trig.omc));
				t2_s10[i] <= T2_W'(c_s9[i]) * T2_W'(signed'(s9_trig.sn));
			end
			vec_s10  <= s9_side.vec;
			zero_s10 <= s9_side.zero;
		end
	end

	// output register: round, saturate, zero-axis bypass
	logic [2:0][CW-1:0] out_q;
	logic               zero_q;
	logic               sat_q;

	always_ff @(posedge clk) begin
		logic signed [ACC_W-1:0] acc;
		logic signed [ACC_W-1:0] r;
		logic                    clip;
		if (en) begin
			clip = 1'b0;
			for (int i = 0; i < 3; i++) begin
				acc = t0_s10[i] + ACC_W'(t1_s10[i]) - ACC_W'(t2_s10[i])
				    + (ACC_W'(1) <<< (U - 1));
				r = acc >>> U;
				if (r > SAT_HI) begin
					r    = SAT_HI;
					clip = 1'b1;
				end else if (r < SAT_LO) begin
					r    = SAT_LO;
					clip = 1'b1;
				end
				out_q[i] <= zero_s10 ? vec_s10[i] : r[CW-1:0];
			end
			zero_q <= zero_s10;
			sat_q  <= clip && !zero_s10;
		end
	end

	assign m_axis_tdata = OUT_TW'(out_q);
	assign m_axis_tuser = {sat_q, zero_q};

endmodule
